### sv/top_k_nearest_max_heap_defines.svh
// Assertion macros for the bounded top-k heap.
// Used by the top level; expects clock and reset in the calling scope.
`ifndef TOP_K_NEAREST_MAX_HEAP_DEFINES_SVH
`define TOP_K_NEAREST_MAX_HEAP_DEFINES_SVH

// cond in a cycle implies cons in the same cycle
`define TKNH_ASSERT_SAME(lbl, cond, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |-> (cons)) \
      else $error(msg);

// cond in a cycle implies cons in the next cycle
`define TKNH_ASSERT_NEXT(lbl, cond, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) \
      else $error(msg);

`endif

### sv/tknh_pkg.sv
// Shared types and constants for the bounded top-k heap.
// No dependencies.
package tknh_pkg;

   localparam int HEAP_DEPTH_DEF = 256;
   localparam int DATA_W         = 32;
   localparam int CAP_W          = 9;
   localparam int ENTRY_W        = 9;
   localparam int CSR_ADDR_W     = 2;

   localparam logic [CAP_W-1:0]      CAP_RESET    = 9'd256;
   localparam logic [CSR_ADDR_W-1:0] CSR_CAPACITY = 2'd0;

   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;

   typedef struct packed {
      logic [1:0]        operation;
      logic [7:0]        slot_index;
      logic [DATA_W-1:0] item_id;
      logic [DATA_W-1:0] item_distance;
   } req_type;

   typedef struct packed {
      logic               stored;
      logic               slot_valid;
      logic [DATA_W-1:0]  out_id;
      logic [DATA_W-1:0]  out_distance;
      logic [ENTRY_W-1:0] entry_count;
   } rsp_type;

   // one heap slot: key and id
   typedef struct packed {
      logic [DATA_W-1:0] key;
      logic [DATA_W-1:0] id;
   } entry_type;

endpackage

### sv/tknh_ram.sv
// Heap slot storage: one write port, one read port, registered read data.
// Depends on tknh_pkg (entry_type).
module tknh_ram #(
   parameter int DEPTH = tknh_pkg::HEAP_DEPTH_DEF,
   parameter int IDX_W = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [IDX_W-1:0]     wr_addr,
   input  tknh_pkg::entry_type  wr_data,
   input  logic                 rd_en,
   input  logic [IDX_W-1:0]     rd_addr,
   output tknh_pkg::entry_type  rd_data
);
   import tknh_pkg::*;

   entry_type mem_ff [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/tknh_csr.sv
// APB-style register port holding the capacity, plus its clamped value.
// Depends on tknh_pkg (widths, reset value, register address).
module tknh_csr #(
   parameter int HEAP_DEPTH = tknh_pkg::HEAP_DEPTH_DEF,
   parameter int CNT_W      = $clog2(HEAP_DEPTH + 1)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [tknh_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [tknh_pkg::DATA_W-1:0]     pwdata,
   output logic [tknh_pkg::DATA_W-1:0]     prdata,
   output logic                            pready,
   output logic [CNT_W-1:0]                cap_eff
);
   import tknh_pkg::*;

   logic [CAP_W-1:0] cap_ff, cap_in;

   always_comb begin
      cap_in = cap_ff;
      if (psel && penable && pwrite && (paddr == CSR_CAPACITY)) begin
         cap_in = pwdata[CAP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else begin
         cap_ff <= cap_in;
      end
   end

   // zero acts as one, anything past the heap depth saturates
   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = CNT_W'(1);
      end else if (32'(cap_ff) > HEAP_DEPTH) begin
         cap_eff = CNT_W'(HEAP_DEPTH);
      end else begin
         cap_eff = CNT_W'(cap_ff);
      end
   end

   assign prdata = (paddr == CSR_CAPACITY) ? DATA_W'(cap_ff) : '0;
   assign pready = 1'b1;

endmodule

### sv/top_k_nearest_max_heap.sv
// Top level of the bounded top-k max-heap: sequencer, shared comparator.
// Depends on tknh_pkg, tknh_ram, tknh_csr and the assertion macro header.
//
//  - Commands enter on req_item, transferred at a clock edge with start high
//    and busy low: clear, insert a candidate, read a slot.
//  - Each command gives one result on rsp_result, marked by rsp_valid for one
//    cycle. The receiver cannot stall. The next command may be transferred
//    in the cycle the result is shown, not before.
//  - Steps: clear, unused code and out-of-range read answer straight from idle;
//    a read fetches the slot, then reports it. An insert below capacity appends
//    and climbs, one parent read per level; on a full heap it reads the root,
//    then rejects or replaces it and sinks, reading both children (right if
//    present) per level. A stored insert writes the entry, then reads the
//    root back. Each level read uses the one slot memory and shared comparator.
//  - Capacity is written through the APB-style port; the user must write it
//    only while idle, which the block does not check. Zero acts as one,
//    values past the heap depth saturate.
//  - Reset (synchronous) empties the heap and sets capacity to 256; the slot
//    memory is not cleared, only slots below the count are ever read.
`include "top_k_nearest_max_heap_defines.svh"
module top_k_nearest_max_heap #(
   parameter int HEAP_DEPTH = tknh_pkg::HEAP_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // command channel
   input  logic                            start,
   output logic                            busy,
   input  tknh_pkg::req_type               req_item,
   // result channel
   output logic                            rsp_valid,
   output tknh_pkg::rsp_type               rsp_result,
   // register port
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [tknh_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [tknh_pkg::DATA_W-1:0]     pwdata,
   output logic [tknh_pkg::DATA_W-1:0]     prdata,
   output logic                            pready
);
   import tknh_pkg::*;

   localparam int IDX_W = $clog2(HEAP_DEPTH);
   localparam int CNT_W = $clog2(HEAP_DEPTH + 1);
   // child index width, roomy enough that 2*i+2 never wraps
   localparam int CIX_W = IDX_W + 2;

   typedef enum logic [11:0] {
      S_IDLE     = 12'b0000_0000_0001,
      S_UP_RD    = 12'b0000_0000_0010,
      S_UP_CMP   = 12'b0000_0000_0100,
      S_RP_RD    = 12'b0000_0000_1000,
      S_RP_CMP   = 12'b0000_0001_0000,
      S_DN_L     = 12'b0000_0010_0000,
      S_DN_R     = 12'b0000_0100_0000,
      S_FIN_WR   = 12'b0000_1000_0000,
      S_ROOT_RD  = 12'b0001_0000_0000,
      S_ROOT_DAT = 12'b0010_0000_0000,
      S_SLOT_RD  = 12'b0100_0000_0000,
      S_SLOT_DAT = 12'b1000_0000_0000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] pos_ff, pos_in;     // hole the moving entry sits in
   logic [IDX_W-1:0] slot_ff, slot_in;
   entry_type        item_ff, item_in;   // entry being inserted
   entry_type        best_ff, best_in;   // larger of item and left child
   logic             best_child_ff, best_child_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic [CNT_W-1:0] cap_eff;

   // memory port
   logic             wr_en, rd_en;
   logic [IDX_W-1:0] wr_addr, rd_addr;
   entry_type        wr_data, rd_data;

   // shared comparator
   logic [DATA_W-1:0] cmp_a, cmp_b;
   logic              cmp_lt;

   // index arithmetic
   logic [IDX_W-1:0] parent_idx, gparent_idx, win_idx;
   logic [CIX_W-1:0] lchild, rchild, win_lchild, count_cx;
   logic             l_ok, r_ok;
   entry_type        winner;

   // assertion terms
   logic             take_insert, take_clear, clear_ok, stored_ok;

   tknh_csr #(
      .HEAP_DEPTH (HEAP_DEPTH),
      .CNT_W      (CNT_W)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cap_eff (cap_eff)
   );

   tknh_ram #(
      .DEPTH (HEAP_DEPTH),
      .IDX_W (IDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign parent_idx  = IDX_W'((pos_ff - IDX_W'(1)) >> 1);
   assign gparent_idx = IDX_W'((parent_idx - IDX_W'(1)) >> 1);
   assign lchild      = CIX_W'({pos_ff, 1'b1});
   assign rchild      = lchild + CIX_W'(1);
   assign count_cx    = CIX_W'(count_ff);
   assign l_ok        = lchild < count_cx;
   assign r_ok        = rchild < count_cx;

   // operand select for the one key comparator: cmp_lt = a < b
   always_comb begin
      case (state_ff)
         S_UP_CMP: begin
            cmp_a = rd_data.key;     // parent smaller than new entry?
            cmp_b = item_ff.key;
         end
         S_DN_R: begin
            cmp_a = best_ff.key;     // right child beats best so far?
            cmp_b = rd_data.key;
         end
         default: begin
            cmp_a = item_ff.key;     // root or left child larger than item?
            cmp_b = rd_data.key;
         end
      endcase
   end
   assign cmp_lt = cmp_a < cmp_b;

   // sift-down winner: right child if strictly larger, else best so far
   always_comb begin
      if (r_ok && cmp_lt) begin
         winner  = rd_data;
         win_idx = IDX_W'(rchild);
      end else begin
         winner  = best_ff;
         win_idx = IDX_W'(lchild);
      end
   end
   assign win_lchild = CIX_W'({win_idx, 1'b1});

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      slot_in       = slot_ff;
      item_in       = item_ff;
      best_in       = best_ff;
      best_child_in = best_child_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      wr_en         = 1'b0;
      wr_addr       = pos_ff;
      wr_data       = item_ff;
      rd_en         = 1'b0;
      rd_addr       = '0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (req_item.operation)
                  OP_CLEAR: begin
                     count_in     = '0;
                     rsp_in       = '0;
                     rsp_valid_in = 1'b1;
                  end
                  OP_INSERT: begin
                     item_in.key = req_item.item_distance;
                     item_in.id  = req_item.item_id;
                     if (count_ff < cap_eff) begin
                        // append at the end, then climb
                        pos_in   = IDX_W'(count_ff);
                        count_in = count_ff + CNT_W'(1);
                        state_in = (count_ff == '0) ? S_FIN_WR : S_UP_RD;
                     end else begin
                        // full (or capacity lowered): try to replace root
                        pos_in   = '0;
                        state_in = S_RP_RD;
                     end
                  end
                  OP_READ: begin
                     if (32'(req_item.slot_index) < 32'(count_ff)) begin
                        slot_in  = IDX_W'(req_item.slot_index);
                        state_in = S_SLOT_RD;
                     end else begin
                        rsp_in             = '0;
                        rsp_in.entry_count = ENTRY_W'(count_ff);
                        rsp_valid_in       = 1'b1;
                     end
                  end
                  default: begin
                     rsp_in             = '0;
                     rsp_in.entry_count = ENTRY_W'(count_ff);
                     rsp_valid_in       = 1'b1;
                  end
               endcase
            end
         end

         S_UP_RD: begin
            rd_en    = 1'b1;
            rd_addr  = parent_idx;
            state_in = S_UP_CMP;
         end

         S_UP_CMP: begin
            if (cmp_lt) begin
               // parent moves down into the hole; fetch next parent meanwhile
               wr_en   = 1'b1;
               wr_data = rd_data;
               pos_in  = parent_idx;
               if (parent_idx == '0) begin
                  state_in = S_FIN_WR;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = gparent_idx;
               end
            end else begin
               state_in = S_FIN_WR;
            end
         end

         S_RP_RD: begin
            rd_en    = 1'b1;
            rd_addr  = '0;
            state_in = S_RP_CMP;
         end

         S_RP_CMP: begin
            if (cmp_lt) begin
               if (l_ok) begin
                  rd_en    = 1'b1;
                  rd_addr  = IDX_W'(lchild);
                  state_in = S_DN_L;
               end else begin
                  state_in = S_FIN_WR;
               end
            end else begin
               // rejected: heap untouched, report the root
               rsp_in.stored       = 1'b0;
               rsp_in.slot_valid   = 1'b0;
               rsp_in.out_id       = rd_data.id;
               rsp_in.out_distance = rd_data.key;
               rsp_in.entry_count  = ENTRY_W'(count_ff);
               rsp_valid_in        = 1'b1;
               state_in            = S_IDLE;
            end
         end

         S_DN_L: begin
            // left child wins only if strictly larger than the item
            if (cmp_lt) begin
               best_in       = rd_data;
               best_child_in = 1'b1;
            end else begin
               best_in       = item_ff;
               best_child_in = 1'b0;
            end
            if (r_ok) begin
               rd_en   = 1'b1;
               rd_addr = IDX_W'(rchild);
            end
            state_in = S_DN_R;
         end

         S_DN_R: begin
            if ((r_ok && cmp_lt) || best_child_ff) begin
               wr_en   = 1'b1;
               wr_data = winner;
               pos_in  = win_idx;
               if (win_lchild < count_cx) begin
                  rd_en    = 1'b1;
                  rd_addr  = IDX_W'(win_lchild);
                  state_in = S_DN_L;
               end else begin
                  state_in = S_FIN_WR;
               end
            end else begin
               state_in = S_FIN_WR;
            end
         end

         S_FIN_WR: begin
            wr_en    = 1'b1;
            state_in = S_ROOT_RD;
         end

         S_ROOT_RD: begin
            rd_en    = 1'b1;
            rd_addr  = '0;
            state_in = S_ROOT_DAT;
         end

         S_ROOT_DAT: begin
            rsp_in.stored       = 1'b1;
            rsp_in.slot_valid   = 1'b0;
            rsp_in.out_id       = rd_data.id;
            rsp_in.out_distance = rd_data.key;
            rsp_in.entry_count  = ENTRY_W'(count_ff);
            rsp_valid_in        = 1'b1;
            state_in            = S_IDLE;
         end

         S_SLOT_RD: begin
            rd_en    = 1'b1;
            rd_addr  = slot_ff;
            state_in = S_SLOT_DAT;
         end

         S_SLOT_DAT: begin
            rsp_in.stored       = 1'b0;
            rsp_in.slot_valid   = 1'b1;
            rsp_in.out_id       = rd_data.id;
            rsp_in.out_distance = rd_data.key;
            rsp_in.entry_count  = ENTRY_W'(count_ff);
            rsp_valid_in        = 1'b1;
            state_in            = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      slot_ff       <= slot_in;
      item_ff       <= item_in;
      best_ff       <= best_in;
      best_child_ff <= best_child_in;
      rsp_ff        <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_ff;

   assign take_insert = start && !busy && (req_item.operation == OP_INSERT);
   assign take_clear  = start && !busy && (req_item.operation == OP_CLEAR);
   assign clear_ok    = rsp_valid && (rsp_result.entry_count == '0);
   assign stored_ok   = (rsp_result.entry_count != '0) && !rsp_result.slot_valid;

   // an insert always runs through the sequencer
   `TKNH_ASSERT_NEXT(a_insert_busy, take_insert, busy, "insert did not make the block busy")

   // a clear answers at once with an empty heap
   `TKNH_ASSERT_NEXT(a_clear_resp, take_clear, clear_ok, "clear did not report an empty heap")

   // a stored insert leaves a nonempty heap and never flags a slot read
   `TKNH_ASSERT_SAME(a_stored_count, rsp_valid && rsp_result.stored, stored_ok, "bad stored result")

endmodule

### bench/tb_heap_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the top-k heap bench: keeps its own copy of the heap and capacity,
// predicts one result per command and checks results in order. Depends on tknh_pkg.
package tb_heap_pkg;
   import tknh_pkg::*;

   localparam int unsigned HEAP_SLOTS = HEAP_DEPTH_DEF;

   class heap_scoreboard;
      bit [DATA_W-1:0] keys [HEAP_SLOTS];
      bit [DATA_W-1:0] ids  [HEAP_SLOTS];
      int unsigned     held;
      bit [CAP_W-1:0]  capacity;
      rsp_type         awaited [$];
      int unsigned     errors;

      function new();
         held     = 0;
         capacity = CAP_RESET;
         errors   = 0;
      endfunction

      function void set_capacity(bit [CAP_W-1:0] value);
         capacity = value;
      endfunction

      function void swap_slots(int unsigned a, int unsigned b);
         bit [DATA_W-1:0] t;
         t = keys[a]; keys[a] = keys[b]; keys[b] = t;
         t = ids[a];  ids[a]  = ids[b];  ids[b]  = t;
      endfunction

      // append and sift up below capacity, else replace a larger root and sift down, or reject
      function bit insert_candidate(bit [DATA_W-1:0] id, bit [DATA_W-1:0] key);
         int unsigned limit, slot, parent, left, right, big;
         limit = (capacity == 0) ? 1 : (capacity > HEAP_SLOTS) ? HEAP_SLOTS : capacity;
         if (held < limit) begin
            slot = held;
            keys[slot] = key;
            ids[slot]  = id;
            held++;
            while (slot > 0) begin
               parent = (slot - 1) / 2;
               if (keys[parent] >= keys[slot]) break;
               swap_slots(parent, slot);
               slot = parent;
            end
            return 1'b1;
         end
         if (held == 0 || key >= keys[0]) return 1'b0;
         keys[0] = key;
         ids[0]  = id;
         slot = 0;
         forever begin
            left  = 2 * slot + 1;
            right = left + 1;
            big   = slot;
            if (left < held && keys[left] > keys[big]) big = left;
            if (right < held && keys[right] > keys[big]) big = right;
            if (big == slot) break;
            swap_slots(slot, big);
            slot = big;
         end
         return 1'b1;
      endfunction

      function rsp_type predict_heap_op(req_type cmd);
         rsp_type r;
         r = '0;
         case (cmd.operation)
            OP_CLEAR: begin
               held = 0;
            end
            OP_INSERT: begin
               r.stored = insert_candidate(cmd.item_id, cmd.item_distance);
               if (held > 0) begin
                  r.out_id       = ids[0];
                  r.out_distance = keys[0];
               end
            end
            OP_READ: begin
               if (cmd.slot_index < held) begin
                  r.slot_valid   = 1'b1;
                  r.out_id       = ids[cmd.slot_index];
                  r.out_distance = keys[cmd.slot_index];
               end
            end
            default: ;
         endcase
         r.entry_count = held[ENTRY_W-1:0];
         return r;
      endfunction

      function void note_command(req_type cmd);
         awaited = {awaited, predict_heap_op(cmd)};
      endfunction

      function void compare_field(string field, logic [DATA_W-1:0] want,
                                  logic [DATA_W-1:0] got);
         if (got !== want) begin
            $error("%s: expected %0h, got %0h", field, want, got);
            errors++;
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (awaited.size() == 0) begin
            $error("result with no command outstanding");
            errors++;
            return;
         end
         want = awaited.pop_front();
         compare_field("stored", DATA_W'(want.stored), DATA_W'(got.stored));
         compare_field("slot_valid", DATA_W'(want.slot_valid), DATA_W'(got.slot_valid));
         compare_field("out_id", want.out_id, got.out_id);
         compare_field("out_distance", want.out_distance, got.out_distance);
         compare_field("entry_count", DATA_W'(want.entry_count), DATA_W'(got.entry_count));
      endfunction
   endclass

endpackage

### bench/tb_top.sv
`timescale 1ns / 100ps
// Top of the top-k heap bench: clock, reset, command and register drivers, monitor.
// Depends on tknh_pkg, tb_heap_pkg and the top_k_nearest_max_heap RTL.
module tb_top;
   import tknh_pkg::*;
   import tb_heap_pkg::*;

   // code 3 has no name in the package; the block must treat it as a no-op
   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // command channel
   logic    start    = 1'b0;
   logic    busy;
   req_type req_item = '0;

   // result channel
   logic    rsp_valid;
   rsp_type rsp_result;

   // register port
   logic                  psel    = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr   = '0;
   logic [DATA_W-1:0]     pwdata  = '0;
   logic [DATA_W-1:0]     prdata;
   logic                  pready;

   heap_scoreboard board = new();

   always #2 clock = ~clock;

   top_k_nearest_max_heap dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_valid  (rsp_valid),
      .rsp_result (rsp_result),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   // Results cannot be held off, so every strobed cycle is checked right away
   // against the oldest outstanding prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) board.check_result(rsp_result);
   end

   // Drivers run on the falling edge and all end on a falling edge, so each
   // task may assign start exactly once in the step it begins in.

   // Hold the command until a transfer: start high and busy low at a rising edge.
   task automatic send_command(input req_type cmd);
      start    <= 1'b1;
      req_item <= cmd;
      do @(posedge clock); while (busy !== 1'b0);
      board.note_command(cmd);
      @(negedge clock);
   endtask

   task automatic pause_sender(input int unsigned cycles);
      start <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // Sender stays quiet until every predicted result has come and the block is idle.
   task automatic wait_for_results();
      start <= 1'b0;
      while (board.awaited.size() != 0 || busy !== 1'b0) @(posedge clock);
      @(negedge clock);
   endtask

   // Setup cycle, then access cycle; the write lands at the edge with pready high.
   task automatic write_capacity(input bit [CAP_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_CAPACITY;
      pwdata  <= DATA_W'(value);
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      board.set_capacity(value);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   function automatic req_type make_command(logic [1:0] op, logic [7:0] slot,
                                            logic [DATA_W-1:0] id,
                                            logic [DATA_W-1:0] distance);
      req_type c;
      c.operation     = op;
      c.slot_index    = slot;
      c.item_id       = id;
      c.item_distance = distance;
      return c;
   endfunction

   // Mostly inserts and reads. Reads lean toward held slots; distances mix
   // tiny values (ties), full-range bits, float-like patterns and values
   // right around the current root (strict-compare edge on the replace path).
   function automatic req_type random_command(input int unsigned clear_pct);
      req_type     c;
      int unsigned pick;
      c.slot_index    = 8'($urandom_range(0, 255));
      c.item_id       = $urandom;
      c.item_distance = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < clear_pct)           c.operation = OP_CLEAR;
      else if (pick < clear_pct + 2)  c.operation = OP_UNUSED;
      else if (pick < clear_pct + 30) c.operation = OP_READ;
      else                            c.operation = OP_INSERT;
      if (c.operation == OP_READ && $urandom_range(0, 3) != 0)
         c.slot_index = 8'($urandom_range(0, (board.held > 255) ? 255 : board.held));
      if (c.operation == OP_INSERT) begin
         case ($urandom_range(0, 3))
            0: c.item_distance = $urandom_range(0, 15);
            1: ;
            2: c.item_distance = {1'b0, 8'($urandom_range(96, 160)), 23'($urandom)};
            default: begin
               if (board.held > 0)
                  c.item_distance = board.keys[0] + DATA_W'($urandom_range(0, 2)) - 1;
            end
         endcase
      end
      return c;
   endfunction

   // One phase: drain, set capacity, then random commands. Phases with idling
   // also drain midway so at least one gap covers the block's full result path.
   task automatic run_phase(input bit [CAP_W-1:0] cap, input int unsigned count,
                            input int unsigned clear_pct, input int unsigned idle_pct);
      wait_for_results();
      write_capacity(cap);
      for (int unsigned k = 0; k < count; k++) begin
         if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct)
            pause_sender($urandom_range(1, 16));
         if (idle_pct != 0 && k == count / 2) wait_for_results();
         send_command(random_command(clear_pct));
      end
   endtask

   // Hard stop: far beyond the slowest correct run (~1250 commands, each at
   // its slowest, plus the longest idle gaps).
   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed, reset capacity of 256: empty read, unused code, field
      // extremes, a sign-bit key, an equal-key sift-up that must not swap,
      // out-of-range read, clear and read after clear.
      send_command(make_command(OP_READ,   8'd0,   '0, '0));
      send_command(make_command(OP_UNUSED, 8'hFF,  '1, '1));
      send_command(make_command(OP_INSERT, 8'd0,   32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_command(make_command(OP_INSERT, 8'd0,   32'h0,         32'h0));
      send_command(make_command(OP_INSERT, 8'd0,   32'h1234_5678, 32'h8000_0000));
      send_command(make_command(OP_INSERT, 8'd0,   32'h0000_000A, 32'h8000_0000));
      send_command(make_command(OP_INSERT, 8'd0,   32'h0000_000B, 32'h8000_0000));
      send_command(make_command(OP_READ,   8'd255, '0, '0));
      send_command(make_command(OP_READ,   8'd3,   '0, '0));
      send_command(make_command(OP_READ,   8'd4,   '0, '0));
      send_command(make_command(OP_CLEAR,  8'd0,   '0, '0));
      send_command(make_command(OP_READ,   8'd0,   '0, '0));

      // Capacity 3: fill, reject equal-to-root, replace with left child
      // winning the tie between two equal children, reject a larger key.
      wait_for_results();
      write_capacity(9'd3);
      send_command(make_command(OP_INSERT, 8'd0, 32'd1, 32'd10));
      send_command(make_command(OP_INSERT, 8'd0, 32'd2, 32'd7));
      send_command(make_command(OP_INSERT, 8'd0, 32'd3, 32'd7));
      send_command(make_command(OP_INSERT, 8'd0, 32'd4, 32'd10));
      send_command(make_command(OP_INSERT, 8'd0, 32'd5, 32'd1));
      send_command(make_command(OP_READ,   8'd0, '0, '0));
      send_command(make_command(OP_READ,   8'd1, '0, '0));
      send_command(make_command(OP_READ,   8'd2, '0, '0));
      send_command(make_command(OP_INSERT, 8'd0, 32'd6, 32'd20));

      // Random phases. Capacity 1 starts below the held count; 0 acts as 1;
      // 511 and 300 saturate and the long phase fills all 256 slots; 9 then
      // drops far below the count so sift-down runs over a full heap.
      run_phase(9'd1,   60,  5, 15);
      run_phase(9'd0,   40,  5, 30);
      run_phase(9'd4,   100, 4, 10);
      run_phase(9'd511, 420, 0, 12);
      run_phase(9'd9,   120, 1, 20);
      run_phase(9'd300, 150, 2, 8);
      run_phase(9'd256, 150, 2, 25);
      // last stretch runs back to back
      run_phase(9'd17,  150, 3, 0);

      wait_for_results();
      repeat (30) @(posedge clock);
      if (board.errors == 0 && board.awaited.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+sv
sv/tknh_pkg.sv
sv/tknh_ram.sv
sv/tknh_csr.sv
sv/top_k_nearest_max_heap.sv
bench/tb_heap_pkg.sv
bench/tb_top.sv
